// File: design/assert_macros.svh
// Assertion macros shared by the scanline-to-rectangles RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RSR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Expression must never be true at a clock edge outside reset.
`define RSR_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

// File: design/rsr_pkg.sv
// Shared types and constants for the scanline-to-rectangles block.
// No dependencies; used by every module of the block except rsr_ram.
`timescale 1ns / 1ps
`default_nettype none
package rsr_pkg;

  localparam int COORD_W  = 16;
  localparam int SPAN_W   = 11;
  localparam int AREA_W   = 48;
  localparam int PROD_W   = SPAN_W + COORD_W;
  localparam int EPOCH_W  = 8;
  localparam int WORD_W   = EPOCH_W + COORD_W;
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PW   = 3;
  localparam int OUT_CW   = 4;

  localparam logic signed [COORD_W-1:0] NO_EDGE   = 16'sd32767;
  localparam logic [SPAN_W-1:0]         SPAN_CAP  = 11'd1024;
  localparam logic [AREA_W-1:0]         AREA_MAX  = '1;
  localparam logic [EPOCH_W-1:0]        EPOCH_MAX = '1;

  typedef enum logic {
    OP_BEGIN  = 1'b0,
    OP_COLUMN = 1'b1
  } op_e;

  typedef struct packed {
    op_e                        op;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  x;
    logic                       run_end;
    logic                       in_win;
    logic [EPOCH_W-1:0]         epoch;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SPAN_W-1:0]         w;
    logic [COORD_W-1:0]        h;
  } rect_t;

  typedef struct packed {
    logic              valid;
    logic              is_begin;
    logic              a_valid;
    rect_t             a;
    logic [PROD_W-1:0] a_prod;
    logic              b_valid;
    rect_t             b;
    logic [PROD_W-1:0] b_prod;
  } merge_out_t;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    rect_t             rect;
    logic              last;
  } result_t;

endpackage
`default_nettype wire

// File: design/rsr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Reads return the contents before a write to the same address. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rsr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: design/rsr_merge.sv
// Column merge stage: resolves the stored top edge, updates the pending rectangle
// and produces the store write-back. Depends on rsr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rsr_merge (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  wire rsr_pkg::item_t               item_i,
  input  wire logic [rsr_pkg::WORD_W-1:0]   rd_word_i,
  output logic                              wr_en_o,
  output logic      [rsr_pkg::WORD_W-1:0]   wr_word_o,
  output rsr_pkg::merge_out_t               mo_o
);

  logic                                 ov_q, ov_d;
  logic signed [rsr_pkg::COORD_W-1:0]   left_q, left_d;
  logic signed [rsr_pkg::COORD_W-1:0]   top_q, top_d;
  logic [rsr_pkg::SPAN_W-1:0]           span_q, span_d;
  rsr_pkg::merge_out_t                  mo_q, mo_d;

  logic signed [rsr_pkg::COORD_W-1:0]   t;
  logic                                 below;
  logic                                 mergeable;
  logic [rsr_pkg::COORD_W+1:0]          x_ext;
  logic [rsr_pkg::COORD_W+1:0]          end_ext;

  always_comb begin
    if (rd_word_i[rsr_pkg::WORD_W-1:rsr_pkg::COORD_W] == item_i.epoch) begin
      t = $signed(rd_word_i[rsr_pkg::COORD_W-1:0]);
    end else begin
      t = rsr_pkg::NO_EDGE;
    end
    below     = t < item_i.y;
    x_ext     = {{2{item_i.x[rsr_pkg::COORD_W-1]}}, item_i.x};
    end_ext   = {{2{left_q[rsr_pkg::COORD_W-1]}}, left_q}
              + {7'b0, span_q};
    mergeable = ov_q && (top_q == t) && (x_ext == end_ext) && (span_q < rsr_pkg::SPAN_CAP);

    ov_d      = ov_q;
    left_d    = left_q;
    top_d     = top_q;
    span_d    = span_q;
    wr_en_o   = 1'b0;
    wr_word_o = {item_i.epoch, rsr_pkg::NO_EDGE};
    mo_d      = '0;

    if (valid_i) begin
      mo_d.valid = 1'b1;
      if (item_i.op == rsr_pkg::OP_BEGIN) begin
        mo_d.is_begin = 1'b1;
        ov_d          = 1'b0;
      end else begin
        if (item_i.in_win) begin
          wr_en_o = 1'b1;
          if (below) begin
            if (mergeable) begin
              span_d = span_q + 1'b1;
            end else begin
              mo_d.a_valid = ov_q;
              left_d       = item_i.x;
              top_d        = t;
              span_d       = 11'd1;
              ov_d         = 1'b1;
            end
          end else begin
            wr_word_o    = {item_i.epoch, item_i.y};
            mo_d.a_valid = ov_q;
            ov_d         = 1'b0;
          end
        end
        if (item_i.run_end && ov_d) begin
          mo_d.b_valid = 1'b1;
          ov_d         = 1'b0;
        end
      end
    end

    mo_d.a.x    = left_q;
    mo_d.a.y    = top_q;
    mo_d.a.w    = span_q;
    mo_d.a.h    = 16'(item_i.y - top_q);
    mo_d.a_prod = rsr_pkg::PROD_W'(mo_d.a.w) * rsr_pkg::PROD_W'(mo_d.a.h);
    mo_d.b.x    = left_d;
    mo_d.b.y    = top_d;
    mo_d.b.w    = span_d;
    mo_d.b.h    = 16'(item_i.y - top_d);
    mo_d.b_prod = rsr_pkg::PROD_W'(mo_d.b.w) * rsr_pkg::PROD_W'(mo_d.b.h);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      left_q <= '0;
      top_q  <= '0;
      span_q <= '0;
      mo_q   <= '0;
    end else begin
      ov_q   <= ov_d;
      left_q <= left_d;
      top_q  <= top_d;
      span_q <= span_d;
      mo_q   <= mo_d;
    end
  end

  assign mo_o = mo_q;

  `RSR_ASSERT(a_span_range, clk_i, rst_ni, ov_q |-> (span_q != '0 && span_q <= rsr_pkg::SPAN_CAP))
  `RSR_ASSERT_NEVER(a_b_without_column, clk_i, rst_ni, mo_q.b_valid && mo_q.is_begin)

endmodule
`default_nettype wire

// File: design/rsr_area.sv
// Area stage: accumulates the saturating running area and forms result words.
// Depends on rsr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rsr_area (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire rsr_pkg::merge_out_t mo_i,
  output rsr_pkg::result_t         res0_o,
  output rsr_pkg::result_t         res1_o,
  output logic [1:0]               n_push_o
);

  logic [rsr_pkg::AREA_W-1:0] area_q, area_d;
  logic [rsr_pkg::PROD_W-1:0] pa, pb;
  logic [rsr_pkg::AREA_W:0]   s1, s2;
  logic [rsr_pkg::AREA_W-1:0] sum1, sum2;

  always_comb begin
    pa   = mo_i.a_valid ? mo_i.a_prod : '0;
    pb   = mo_i.b_valid ? mo_i.b_prod : '0;
    s1   = {1'b0, area_q} + 49'(pa);
    s2   = {1'b0, area_q} + 49'(pa) + 49'(pb);
    sum1 = s1[rsr_pkg::AREA_W] ? rsr_pkg::AREA_MAX : s1[rsr_pkg::AREA_W-1:0];
    sum2 = s2[rsr_pkg::AREA_W] ? rsr_pkg::AREA_MAX : s2[rsr_pkg::AREA_W-1:0];

    res1_o.rect = mo_i.b;
    res1_o.area = sum2;
    res1_o.last = 1'b1;
    if (mo_i.a_valid) begin
      res0_o.rect = mo_i.a;
      res0_o.area = sum1;
      res0_o.last = !mo_i.b_valid;
    end else begin
      res0_o.rect = mo_i.b;
      res0_o.area = sum2;
      res0_o.last = 1'b1;
    end

    n_push_o = 2'd0;
    area_d   = area_q;
    if (mo_i.valid) begin
      n_push_o = {1'b0, mo_i.a_valid} + {1'b0, mo_i.b_valid};
      if (mo_i.is_begin) begin
        area_d = '0;
      end else begin
        area_d = sum2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q <= '0;
    end else begin
      area_q <= area_d;
    end
  end

endmodule
`default_nettype wire

// File: design/rsr_fifo.sv
// Output queue: takes up to two result words a cycle, hands out one.
// Depends on rsr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rsr_fifo (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire rsr_pkg::result_t            d0_i,
  input  wire rsr_pkg::result_t            d1_i,
  input  wire logic [1:0]                  n_push_i,
  input  wire logic                        pop_i,
  output logic                             valid_o,
  output rsr_pkg::result_t                 head_o,
  output logic      [rsr_pkg::OUT_CW-1:0]  count_o
);

  rsr_pkg::result_t            fifo_q [rsr_pkg::OUT_DEPTH];
  logic [rsr_pkg::OUT_PW-1:0]  wp_q, rp_q;
  logic [rsr_pkg::OUT_PW-1:0]  wp_next;
  logic [rsr_pkg::OUT_CW-1:0]  count_q;
  logic                        do_pop;

  assign do_pop  = pop_i && (count_q != '0);
  assign wp_next = wp_q + 1'b1;
  assign valid_o = count_q != '0;
  assign head_o  = fifo_q[rp_q];
  assign count_o = count_q;

  always_ff @(posedge clk_i) begin
    if (n_push_i != 2'd0) begin
      fifo_q[wp_q] <= d0_i;
    end
    if (n_push_i == 2'd2) begin
      fifo_q[wp_next] <= d1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_q + rsr_pkg::OUT_PW'(n_push_i);
      rp_q    <= rp_q + rsr_pkg::OUT_PW'(do_pop);
      count_q <= count_q + rsr_pkg::OUT_CW'(n_push_i) - rsr_pkg::OUT_CW'(do_pop);
    end
  end

  `RSR_ASSERT_NEVER(a_fifo_overflow, clk_i, rst_ni, ({1'b0, count_q} + 5'(n_push_i)) > 5'(rsr_pkg::OUT_DEPTH))

endmodule
`default_nettype wire

// File: design/region_scanline_to_rectangles.sv
// A column word is registered at the input, in the merge stage and in the output queue.
// Throughput: one input word per cycle while s_axis_tready is high; an item with two
// results hands them out one at a time. The top-edge store is a single-port-write RAM
// tagged with an 8-bit generation; a begin word bumps the generation, and every 256th
// begin runs a clearing pass over all MAX_COLUMNS entries. Reset is asynchronous, active
// low; after it a clearing pass over all entries runs with s_axis_tready low.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module region_scanline_to_rectangles #(
  parameter int MAX_COLUMNS = 1024
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,   // line_y [15:0], column_x [31:16]
  input  wire logic         s_axis_tuser,   // op
  input  wire logic         s_axis_tlast,   // run_end
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [111:0] m_axis_tdata,   // rect_x, rect_y, rect_width, rect_height,
                                            // area_total, zero fill
  output logic              m_axis_tlast    // last
);

  localparam int AW = $clog2(MAX_COLUMNS);

  logic signed [rsr_pkg::COORD_W-1:0] origin_q, origin_d;
  logic [rsr_pkg::EPOCH_W-1:0]        epoch_q, epoch_d;
  logic                               clr_active_q, clr_active_d;
  logic [AW-1:0]                      clr_cnt_q, clr_cnt_d;
  logic                               s1_valid_q;
  rsr_pkg::item_t                     s1_q, item_d;
  logic [AW-1:0]                      s1_addr_q;
  logic                               fwd_valid_q;
  logic [AW-1:0]                      fwd_addr_q;
  logic [rsr_pkg::WORD_W-1:0]         fwd_word_q;

  logic                               in_fire;
  logic signed [rsr_pkg::COORD_W-1:0] in_y, in_x;
  logic [rsr_pkg::COORD_W+1:0]        idx;
  logic [4:0]                         budget;

  logic                               ram_we;
  logic [AW-1:0]                      ram_waddr;
  logic [rsr_pkg::WORD_W-1:0]         ram_wdata;
  logic [rsr_pkg::WORD_W-1:0]         ram_rdata;
  logic [rsr_pkg::WORD_W-1:0]         rd_word;

  logic                               m_wr_en;
  logic [rsr_pkg::WORD_W-1:0]         m_wr_word;
  rsr_pkg::merge_out_t                mo;
  rsr_pkg::result_t                   res0, res1, head;
  logic [1:0]                         n_push;
  logic [rsr_pkg::OUT_CW-1:0]         fifo_count;

  assign budget = {1'b0, fifo_count} + {3'b0, s1_valid_q, 1'b0} + {3'b0, mo.valid, 1'b0};
  assign s_axis_tready = !clr_active_q && (budget <= 5'(rsr_pkg::OUT_DEPTH - 2));
  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_y = $signed(s_axis_tdata[15:0]);
    in_x = $signed(s_axis_tdata[31:16]);
    idx  = {{2{in_x[rsr_pkg::COORD_W-1]}}, in_x} - {{2{origin_q[rsr_pkg::COORD_W-1]}}, origin_q};

    item_d.op      = rsr_pkg::op_e'(s_axis_tuser);
    item_d.y       = in_y;
    item_d.x       = in_x;
    item_d.run_end = s_axis_tlast;
    item_d.in_win  = !idx[rsr_pkg::COORD_W+1]
                   && (idx[rsr_pkg::COORD_W:0] < 17'(MAX_COLUMNS));
    item_d.epoch   = epoch_q;

    origin_d     = origin_q;
    epoch_d      = epoch_q;
    clr_active_d = clr_active_q;
    clr_cnt_d    = clr_cnt_q;
    if (clr_active_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(MAX_COLUMNS - 1)) begin
        clr_active_d = 1'b0;
      end
    end
    if (in_fire && item_d.op == rsr_pkg::OP_BEGIN) begin
      origin_d = in_x;
      if (epoch_q == rsr_pkg::EPOCH_MAX) begin
        epoch_d      = '0;
        clr_active_d = 1'b1;
        clr_cnt_d    = '0;
      end else begin
        epoch_d = epoch_q + 1'b1;
      end
    end

    ram_we    = clr_active_q || m_wr_en;
    ram_waddr = clr_active_q ? clr_cnt_q : s1_addr_q;
    ram_wdata = clr_active_q ? {rsr_pkg::EPOCH_W'(0), rsr_pkg::NO_EDGE} : m_wr_word;
    rd_word   = (fwd_valid_q && fwd_addr_q == s1_addr_q) ? fwd_word_q : ram_rdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q     <= '0;
      epoch_q      <= '0;
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
      s1_valid_q   <= 1'b0;
      fwd_valid_q  <= 1'b0;
    end else begin
      origin_q     <= origin_d;
      epoch_q      <= epoch_d;
      clr_active_q <= clr_active_d;
      clr_cnt_q    <= clr_cnt_d;
      s1_valid_q   <= in_fire;
      if (ram_we) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q      <= item_d;
      s1_addr_q <= idx[AW-1:0];
    end
    if (ram_we) begin
      fwd_addr_q <= ram_waddr;
      fwd_word_q <= ram_wdata;
    end
  end

  rsr_ram #(
    .WIDTH (rsr_pkg::WORD_W),
    .DEPTH (MAX_COLUMNS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (idx[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  rsr_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s1_valid_q),
    .item_i    (s1_q),
    .rd_word_i (rd_word),
    .wr_en_o   (m_wr_en),
    .wr_word_o (m_wr_word),
    .mo_o      (mo)
  );

  rsr_area u_area (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .mo_i     (mo),
    .res0_o   (res0),
    .res1_o   (res1),
    .n_push_o (n_push)
  );

  rsr_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .d0_i     (res0),
    .d1_i     (res1),
    .n_push_i (n_push),
    .pop_i    (m_axis_tready),
    .valid_o  (m_axis_tvalid),
    .head_o   (head),
    .count_o  (fifo_count)
  );

  assign m_axis_tdata = {5'b0, head.area, head.rect.h, head.rect.w, head.rect.y, head.rect.x};
  assign m_axis_tlast = head.last;

  `RSR_ASSERT(a_clear_only_behind_begin, clk_i, rst_ni, (clr_active_q && s1_valid_q) |-> (s1_q.op == rsr_pkg::OP_BEGIN))
  `RSR_ASSERT(a_clear_at_generation_zero, clk_i, rst_ni, clr_active_q |-> (epoch_q == '0))
  `RSR_ASSERT_NEVER(a_no_merge_write_in_clear, clk_i, rst_ni, clr_active_q && m_wr_en)

endmodule
`default_nettype wire

// File: tb/region_scanline_to_rectangles_tb.sv
// Self-checking testbench for the scanline-to-rectangles block: streams column words and
// compares every rectangle word with a behavioural prediction of the open-edge store.
// Depends on rsr_pkg and region_scanline_to_rectangles; reads and writes no files.
`timescale 1ns / 1ps
module region_scanline_to_rectangles_tb;

  localparam int MAX_COLUMNS = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int CALM_WORDS = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_END = 300;
  localparam int SPREAD_COLS = 64;

  typedef struct {
    rsr_pkg::op_e       op;
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic               run_end;
  } col_word_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [10:0]        w;
    logic [15:0]        h;
    logic [47:0]        area;
    logic               last;
  } rect_word_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic         m_axis_tlast;

  region_scanline_to_rectangles #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  col_word_t  column_words[$];
  rect_word_t rect_expected[$];
  col_word_t  word_on_bus;
  rect_word_t rect_seen;
  rect_word_t rect_want;
  int         words_total = 0;
  int         words_accepted = 0;
  int         fail_count = 0;
  int         cycle_count = 0;
  int         send_gap = 0;
  int         recv_gap = 0;
  int         hold_left = 0;
  int         holds_done = 0;
  int         gen_origin = 0;
  logic       calm = 1'b0;

  // Predicted block state.
  logic signed [15:0] edge_top[MAX_COLUMNS];
  int                 col_origin = 0;
  bit                 rect_open = 1'b0;
  int                 rect_left = 0;
  int                 rect_top = 0;
  int                 rect_span = 0;
  logic [47:0]        area_acc = '0;

  function automatic rect_word_t close_open_rect(input int line_now);
    rect_word_t r;
    logic [15:0] h;
    logic [26:0] add;
    logic [48:0] sum;
    h = 16'(line_now - rect_top);
    r.w = rect_span[10:0];
    add = r.w * h;
    sum = {1'b0, area_acc} + add;
    area_acc = sum[48] ? rsr_pkg::AREA_MAX : sum[47:0];
    r.x = rect_left[15:0];
    r.y = rect_top[15:0];
    r.h = h;
    r.area = area_acc;
    r.last = 1'b0;
    rect_open = 1'b0;
    return r;
  endfunction

  function automatic void predict_rectangles(input col_word_t wd);
    rect_word_t made[$];
    int idx;
    logic signed [15:0] t;
    if (wd.op == rsr_pkg::OP_BEGIN) begin
      foreach (edge_top[i]) edge_top[i] = rsr_pkg::NO_EDGE;
      col_origin = int'(wd.x);
      area_acc = '0;
      rect_open = 1'b0;
      return;
    end
    idx = int'(wd.x) - col_origin;
    if (idx >= 0 && idx < MAX_COLUMNS) begin
      t = edge_top[idx];
      if (t < wd.y) begin
        edge_top[idx] = rsr_pkg::NO_EDGE;
        if (rect_open && rect_top == int'(t) && int'(wd.x) == rect_left + rect_span &&
            rect_span < int'(rsr_pkg::SPAN_CAP)) begin
          rect_span++;
        end else begin
          if (rect_open) made.push_back(close_open_rect(wd.y));
          rect_left = int'(wd.x);
          rect_top = int'(t);
          rect_span = 1;
          rect_open = 1'b1;
        end
      end else begin
        edge_top[idx] = wd.y;
        if (rect_open) made.push_back(close_open_rect(wd.y));
      end
    end
    if (wd.run_end && rect_open) made.push_back(close_open_rect(wd.y));
    if (made.size() > 0) made[made.size()-1].last = 1'b1;
    foreach (made[i]) rect_expected.push_back(made[i]);
  endfunction

  function automatic void add_word(input rsr_pkg::op_e op, input int y, input int x,
                                   input bit run_end);
    col_word_t wd;
    wd.op = op;
    wd.y = 16'(y);
    wd.x = 16'(x);
    wd.run_end = run_end;
    if (op == rsr_pkg::OP_BEGIN) gen_origin = int'(wd.x);
    column_words.push_back(wd);
  endfunction

  // One region: a begin, then scan lines whose runs often repeat those of the line above
  // so that open edges get closed into rectangles.
  function automatic void add_region();
    int origin;
    int width;
    int lines;
    int y;
    int c;
    int len;
    int run_lo[$];
    int run_len[$];
    width = $urandom_range(2, 40);
    case ($urandom_range(0, 7))
      0: origin = -32768;
      1: origin = 32767 - width;
      default: origin = int'($urandom_range(0, 65535 - 64)) - 32768;
    endcase
    add_word(rsr_pkg::OP_BEGIN, $urandom, origin, $urandom_range(0, 1));
    y = int'($urandom_range(0, 40000)) - 32768;
    lines = $urandom_range(2, 8);
    for (int k = 0; k < lines; k++) begin
      if (k > 0) begin
        if ($urandom_range(0, 9) == 0) y += $urandom_range(1000, 30000);
        else y += $urandom_range(1, 200);
        if ($urandom_range(0, 19) == 0 || y > 32767) y = 32767;
      end
      if (k == 0 || $urandom_range(0, 2) == 0) begin
        run_lo.delete();
        run_len.delete();
        c = origin + $urandom_range(0, 2);
        while (c <= origin + width && c <= 32767) begin
          len = $urandom_range(1, 6);
          if (c + len - 1 > 32767) len = 32767 - c + 1;
          run_lo.push_back(c);
          run_len.push_back(len);
          c += len + $urandom_range(1, 4);
        end
      end
      foreach (run_lo[r]) begin
        for (int j = 0; j < run_len[r]; j++) begin
          add_word(rsr_pkg::OP_COLUMN, y, run_lo[r] + j,
                   j == run_len[r] - 1 && $urandom_range(0, 11) != 0);
        end
      end
      if (y == 32767) break;
    end
  endfunction

  function automatic void add_noise();
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 3))
        0: add_word($urandom_range(0, 7) == 0 ? rsr_pkg::OP_BEGIN : rsr_pkg::OP_COLUMN,
                    $urandom, $urandom, $urandom_range(0, 1));
        1: add_word(rsr_pkg::OP_COLUMN, $urandom, gen_origin - 1, $urandom_range(0, 1));
        2: add_word(rsr_pkg::OP_COLUMN, $urandom, gen_origin + MAX_COLUMNS,
                    $urandom_range(0, 1));
        default: add_word(rsr_pkg::OP_COLUMN, $urandom, gen_origin + $urandom_range(0, 40),
                          $urandom_range(0, 1));
      endcase
    end
  endfunction

  // Sender: presents queued words and predicts each one as it is accepted.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_rectangles(word_on_bus);
        words_accepted++;
      end
      calm <= column_words.size() < CALM_WORDS;
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 3) - 1;
          s_axis_tvalid <= 1'b0;
        end else if (column_words.size() > 0) begin
          word_on_bus = column_words.pop_front();
          s_axis_tdata <= {word_on_bus.x, word_on_bus.y};
          s_axis_tuser <= word_on_bus.op;
          s_axis_tlast <= word_on_bus.run_end;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness, with two long hold-offs so that the block backs up.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if ((holds_done == 0 && words_accepted >= 80) ||
                 (holds_done == 1 && words_accepted >= 220)) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(1, 3) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      rect_seen.x = m_axis_tdata[15:0];
      rect_seen.y = m_axis_tdata[31:16];
      rect_seen.w = m_axis_tdata[42:32];
      rect_seen.h = m_axis_tdata[58:43];
      rect_seen.area = m_axis_tdata[106:59];
      rect_seen.last = m_axis_tlast;
      if (rect_expected.size() == 0) begin
        fail_count++;
        $display("%0t: expected none, got (%0d,%0d,%0d,%0d,%0d,%0b)",
                 $time, rect_seen.x, rect_seen.y, rect_seen.w, rect_seen.h,
                 rect_seen.area, rect_seen.last);
      end else begin
        rect_want = rect_expected.pop_front();
        if (rect_seen.x !== rect_want.x || rect_seen.y !== rect_want.y ||
            rect_seen.w !== rect_want.w || rect_seen.h !== rect_want.h ||
            rect_seen.area !== rect_want.area || rect_seen.last !== rect_want.last) begin
          fail_count++;
          $display("%0t: expected (%0d,%0d,%0d,%0d,%0d,%0b), got (%0d,%0d,%0d,%0d,%0d,%0b)",
                   $time, rect_want.x, rect_want.y, rect_want.w, rect_want.h,
                   rect_want.area, rect_want.last, rect_seen.x, rect_seen.y,
                   rect_seen.w, rect_seen.h, rect_seen.area, rect_seen.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int spread_base;
    int y_open;
    int y_close;
    foreach (edge_top[i]) edge_top[i] = rsr_pkg::NO_EDGE;

    // Window extremes, the top and bottom lines, and the line that equals no edge.
    add_word(rsr_pkg::OP_COLUMN, -32768, -32768, 1'b0);
    add_word(rsr_pkg::OP_BEGIN, 0, -32768, 1'b0);
    add_word(rsr_pkg::OP_COLUMN, -32768, -32768, 1'b0);
    add_word(rsr_pkg::OP_COLUMN, -32768, -32767, 1'b1);
    add_word(rsr_pkg::OP_COLUMN, 32766, -32768, 1'b0);
    add_word(rsr_pkg::OP_COLUMN, 32766, -32767, 1'b1);
    add_word(rsr_pkg::OP_COLUMN, 32767, -32766, 1'b0);
    add_word(rsr_pkg::OP_COLUMN, 32767, 32767, 1'b1);
    // Last column of the window, one just left of it, and a height that wraps because
    // the run end never came.
    add_word(rsr_pkg::OP_BEGIN, -1, 31744, 1'b1);
    add_word(rsr_pkg::OP_COLUMN, 5, 32767, 1'b0);
    add_word(rsr_pkg::OP_COLUMN, 5, 31743, 1'b1);
    add_word(rsr_pkg::OP_COLUMN, 100, 32767, 1'b0);
    add_word(rsr_pkg::OP_COLUMN, -100, 31744, 1'b1);
    // A gap in the span gives two rectangles from a single word.
    add_word(rsr_pkg::OP_BEGIN, 0, 0, 1'b0);
    add_word(rsr_pkg::OP_COLUMN, 0, 0, 1'b0);
    add_word(rsr_pkg::OP_COLUMN, 0, 1, 1'b0);
    add_word(rsr_pkg::OP_COLUMN, 0, 3, 1'b1);
    add_word(rsr_pkg::OP_COLUMN, 7, 0, 1'b0);
    add_word(rsr_pkg::OP_COLUMN, 7, 1, 1'b0);
    add_word(rsr_pkg::OP_COLUMN, 7, 3, 1'b1);

    // Random regions and noise, dense in rectangles while the receiver holds off.
    while (column_words.size() < RANDOM_END) begin
      if ($urandom_range(0, 9) == 0) add_noise();
      else add_region();
    end

    // A rectangle many columns wide, then a column just beyond the window.
    spread_base = int'($urandom_range(0, 65535 - 1024)) - 32768;
    y_open = int'($urandom_range(0, 32768)) - 32768;
    y_close = y_open + $urandom_range(1, 30000);
    add_word(rsr_pkg::OP_BEGIN, $urandom, spread_base, 1'b0);
    for (int i = 0; i < SPREAD_COLS; i++)
      add_word(rsr_pkg::OP_COLUMN, y_open, spread_base + i, i == SPREAD_COLS - 1);
    for (int i = 0; i < SPREAD_COLS; i++)
      add_word(rsr_pkg::OP_COLUMN, y_close, spread_base + i, i == SPREAD_COLS - 1);
    add_word(rsr_pkg::OP_COLUMN, y_close + 1, spread_base + MAX_COLUMNS, 1'b1);

    // Many short regions over the same few columns, enough to wrap the store generation.
    repeat (260) begin
      add_word(rsr_pkg::OP_BEGIN, $urandom, int'($urandom_range(0, 8)) - 4,
               $urandom_range(0, 1));
      repeat ($urandom_range(0, 2))
        add_word(rsr_pkg::OP_COLUMN, 5 * (int'($urandom_range(0, 2)) - 1),
                 gen_origin + $urandom_range(0, 3), $urandom_range(0, 1));
    end

    words_total = column_words.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_accepted != words_total) @(posedge clk_i);
    while (rect_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
